FILE: hw/rtl/pixel_format_convert_blend_macros.svh
// ----------------------------------------------------------------------------
// pixel_format_convert_blend_macros.svh
// Assertion macros used by the checker of the pixel converter.
// ----------------------------------------------------------------------------
`ifndef PIXEL_FORMAT_CONVERT_BLEND_MACROS_SVH
`define PIXEL_FORMAT_CONVERT_BLEND_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while in reset
`define PFCB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while in reset
`define PFCB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/pfcb_pkg.sv
// ----------------------------------------------------------------------------
// pfcb_pkg
// Formats, modes, register indexes and byte-position helpers for the
// pixel format converter.
// ----------------------------------------------------------------------------
package pfcb_pkg;

    // Pixel formats
    localparam logic [2:0] FMT_RGBA = 3'd0;
    localparam logic [2:0] FMT_BGRA = 3'd1;
    localparam logic [2:0] FMT_ARGB = 3'd2;
    localparam logic [2:0] FMT_ABGR = 3'd3;
    localparam logic [2:0] FMT_RGB  = 3'd4;
    localparam logic [2:0] FMT_BGR  = 3'd5;

    // Alpha modes
    localparam logic [1:0] MODE_STRAIGHT = 2'd0;

    // Register indexes
    localparam logic [1:0] CFG_SRC_FORMAT = 2'd0;
    localparam logic [1:0] CFG_DST_FORMAT = 2'd1;
    localparam logic [1:0] CFG_ALPHA_MODE = 2'd2;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 3;
    localparam int unsigned NUM_CH     = 3;

    // Channel slots
    localparam int unsigned CH_R = 0;
    localparam int unsigned CH_G = 1;
    localparam int unsigned CH_B = 2;

    // One channel's operands for the blend lane
    typedef struct packed {
        logic [7:0] src;
        logic [7:0] dst;
        logic [7:0] alpha;
        logic       blend;
    } t_lane_in;

    // Bit offsets of each channel per format
    function automatic logic [4:0] red_shift(input logic [2:0] fmt);
        case (fmt)
            FMT_RGBA: red_shift = 5'd24;
            FMT_BGRA: red_shift = 5'd8;
            FMT_ARGB: red_shift = 5'd16;
            FMT_RGB:  red_shift = 5'd16;
            default:  red_shift = 5'd0;
        endcase
    endfunction

    function automatic logic [4:0] green_shift(input logic [2:0] fmt);
        case (fmt)
            FMT_RGBA: green_shift = 5'd16;
            FMT_BGRA: green_shift = 5'd16;
            default:  green_shift = 5'd8;
        endcase
    endfunction

    function automatic logic [4:0] blue_shift(input logic [2:0] fmt);
        case (fmt)
            FMT_RGBA: blue_shift = 5'd8;
            FMT_BGRA: blue_shift = 5'd24;
            FMT_ABGR: blue_shift = 5'd16;
            FMT_BGR:  blue_shift = 5'd16;
            default:  blue_shift = 5'd0;
        endcase
    endfunction

    function automatic logic [4:0] alpha_shift(input logic [2:0] fmt);
        case (fmt)
            FMT_ARGB: alpha_shift = 5'd24;
            FMT_ABGR: alpha_shift = 5'd24;
            default:  alpha_shift = 5'd0;
        endcase
    endfunction

    function automatic logic [7:0] take_byte(input logic [31:0] word, input logic [4:0] sh);
        take_byte = 8'(word >> sh);
    endfunction

    // Place the three channels at the byte positions of a format
    function automatic logic [31:0] pack(input logic [2:0] fmt, input logic [7:0] r,
                                         input logic [7:0] g, input logic [7:0] b);
        pack = (32'(r) << red_shift(fmt)) | (32'(g) << green_shift(fmt)) |
               (32'(b) << blue_shift(fmt));
    endfunction

endpackage

FILE: hw/rtl/pfcb_blend_lane.sv
// ----------------------------------------------------------------------------
// pfcb_blend_lane
// Two-stage blend of one channel: weighted sum, then divide by 255.
// ----------------------------------------------------------------------------
module pfcb_blend_lane (
    input  logic              i_clk,
    input  logic              i_en,
    input  pfcb_pkg::t_lane_in i_lane,
    output logic [7:0]        o_result
);
    import pfcb_pkg::*;

    logic [7:0]  inv_alpha;
    logic [15:0] n_sum;
    logic [15:0] r_sum;
    logic        r_blend;
    logic [7:0]  r_src;
    logic [16:0] n_quot;
    logic [7:0]  r_result;

    // Weighted sum s*a + d*(255-a), at most 65025
    always_comb begin
        inv_alpha = ~i_lane.alpha;
        n_sum     = (16'(i_lane.src) * 16'(i_lane.alpha)) +
                    (16'(i_lane.dst) * 16'(inv_alpha));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum   <= n_sum;
            r_blend <= i_lane.blend;
            r_src   <= i_lane.src;
        end
    end

    // Divide by 255: (x + (x >> 8) + 1) >> 8 is exact over the sum's range
    always_comb begin
        n_quot = (17'(r_sum) + 17'(r_sum[15:8]) + 17'd1) >> 8;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result <= r_blend ? n_quot[7:0] : r_src;
        end
    end

    assign o_result = r_result;

endmodule

FILE: hw/rtl/pixel_format_convert_blend.sv
// ----------------------------------------------------------------------------
// pixel_format_convert_blend
// Pixel format conversion between RGBA, BGRA, ARGB, ABGR, RGB and BGR with
// optional alpha blend against the destination pixel.
// ----------------------------------------------------------------------------
// The block takes one pixel beat per clock and returns one result beat per
// input beat, in order, through its register stages: decode, multiply,
// divide by 255 and pack each take one register stage. The whole pipeline
// advances together and holds while a finished beat waits at the output
// under stall, so sustained throughput is one pixel per clock whenever the
// output side takes beats. Configuration writes are taken at any cycle and
// must be made while no beat is in flight.
// ----------------------------------------------------------------------------
module pixel_format_convert_blend (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pfcb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pfcb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [31:0]                    i_src_pixel,
    input  logic [31:0]                    i_dst_pixel,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [31:0]                    o_out_pixel,
    output logic                           o_write_enable
);
    import pfcb_pkg::*;

    logic [2:0] r_src_format;
    logic [2:0] r_dst_format;
    logic [1:0] r_alpha_mode;

    logic       advance;
    logic       r_v1, r_v2, r_v3, r_out_valid;
    logic       r_skip1, r_skip2, r_skip3;

    logic       four_src;
    logic       fmt_ok;
    logic [31:0] sp;
    logic [7:0] a_raw;
    logic [7:0] a_eff;
    logic       n_skip;

    t_lane_in   n_lane [NUM_CH];
    t_lane_in   r_lane [NUM_CH];
    logic [7:0] lane_res [NUM_CH];

    logic [31:0] r_out_pixel;
    logic        r_write_enable;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_format <= FMT_RGBA;
            r_dst_format <= FMT_RGBA;
            r_alpha_mode <= MODE_STRAIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SRC_FORMAT: r_src_format <= i_cfg_data;
                CFG_DST_FORMAT: r_dst_format <= i_cfg_data;
                CFG_ALPHA_MODE: r_alpha_mode <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Advance all stages unless a finished beat is held at the output
    assign advance    = !(r_out_valid && i_out_stall);
    assign o_in_stall = !advance;

    // Decode: pick channel bytes and resolve alpha
    always_comb begin
        four_src = (r_src_format <= FMT_ABGR);
        fmt_ok   = (r_src_format <= FMT_BGR) && (r_dst_format <= FMT_BGR);
        sp       = four_src ? i_src_pixel : {8'h00, i_src_pixel[23:0]};
        a_raw    = take_byte(sp, alpha_shift(r_src_format));
        a_eff    = 8'hFF;
        n_skip   = !fmt_ok;
        if (four_src && (r_alpha_mode != MODE_STRAIGHT)) begin
            if (a_raw == 8'h00) begin
                if ((sp != 32'd0) && r_alpha_mode[1]) begin
                    a_eff = 8'hFF;
                end else begin
                    n_skip = 1'b1;
                end
            end else begin
                a_eff = a_raw;
            end
        end
        n_lane[CH_R].src = take_byte(sp, red_shift(r_src_format));
        n_lane[CH_G].src = take_byte(sp, green_shift(r_src_format));
        n_lane[CH_B].src = take_byte(sp, blue_shift(r_src_format));
        n_lane[CH_R].dst = take_byte(i_dst_pixel, red_shift(r_dst_format));
        n_lane[CH_G].dst = take_byte(i_dst_pixel, green_shift(r_dst_format));
        n_lane[CH_B].dst = take_byte(i_dst_pixel, blue_shift(r_dst_format));
        for (int c = 0; c < NUM_CH; c++) begin
            n_lane[c].alpha = a_eff;
            n_lane[c].blend = (a_eff != 8'hFF);
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_v1        <= i_in_valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_out_valid <= r_v3;
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_lane  <= n_lane;
            r_skip1 <= n_skip;
            r_skip2 <= r_skip1;
            r_skip3 <= r_skip2;
        end
    end

    // Multiply and divide per channel
    for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
        pfcb_blend_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (advance),
            .i_lane   (r_lane[c]),
            .o_result (lane_res[c])
        );
    end

    // Pack into the destination format; drop skipped beats to zero
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_pixel    <= r_skip3 ? 32'd0 :
                              pack(r_dst_format, lane_res[CH_R], lane_res[CH_G],
                                   lane_res[CH_B]);
            r_write_enable <= !r_skip3;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_pixel    = r_out_pixel;
    assign o_write_enable = r_write_enable;

endmodule

FILE: hw/rtl/pfcb_checker.sv
// ----------------------------------------------------------------------------
// pfcb_checker
// Port-level checks of the pixel converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "pixel_format_convert_blend_macros.svh"

module pfcb_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [31:0]                     o_out_pixel,
    input logic                            o_write_enable
);
    logic        in_beat;
    logic        out_held;
    logic        out_free;
    logic        out_skip;
    logic [32:0] out_word;

    assign in_beat  = i_in_valid && !o_in_stall;
    assign out_held = o_out_valid && i_out_stall;
    assign out_free = !i_out_stall;
    assign out_skip = o_out_valid && !o_write_enable;
    assign out_word = {o_out_pixel, o_write_enable};

    // A skipped beat carries a zero pixel
    `PFCB_ASSERT_IMP(a_skip_zero, out_skip, o_out_pixel == 32'd0, "skip not zero")

    // The input stalls only behind a held output beat
    `PFCB_ASSERT_IMP(a_stall_cause, o_in_stall, out_held, "spurious input stall")

    // A held output beat stays put
    `PFCB_ASSERT_NXT(a_out_hold, out_held, o_out_valid && $stable(out_word), "held beat changed")

    // Without output stall an accepted beat comes out of the pipeline
    `PFCB_ASSERT_NXT(a_latency, in_beat ##1 out_free [*3], o_out_valid, "beat lost in pipeline")

endmodule

bind pixel_format_convert_blend pfcb_checker u_pfcb_checker (.*);

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pixel format converter and alpha blender.
// A queue of register writes and pixel beats drives the block in random
// bursts, while the result side stalls on its own pattern. Each accepted
// pixel is run through a local model of the conversion and blend, and every
// result beat is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pfcb_pkg::*;

    // Codes the package does not name
    localparam logic [2:0] FMT_UNDEF_A       = 3'd6;
    localparam logic [2:0] FMT_UNDEF_B       = 3'd7;
    localparam logic [1:0] MODE_BLEND_CLEAR  = 2'd1;
    localparam logic [1:0] MODE_BLEND_OPAQUE = 2'd2;
    localparam logic [1:0] MODE_BLEND_ALT    = 2'd3;
    localparam logic [1:0] CFG_UNUSED        = 2'd3;
    localparam int unsigned CH_A             = 3;

    localparam int RANDOM_PIXELS  = 1800;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_style_t;

    typedef struct {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [31:0]           src;
        logic [31:0]           dst;
    } stim_t;

    typedef struct {
        logic [31:0] pixel;
        logic        we;
    } px_result_t;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic [31:0]           i_src_pixel = '0;
    logic [31:0]           i_dst_pixel = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [31:0]           o_out_pixel;
    logic                  o_write_enable;

    pixel_format_convert_blend i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_src_pixel    (i_src_pixel),
        .i_dst_pixel    (i_dst_pixel),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_pixel    (o_out_pixel),
        .o_write_enable (o_write_enable)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Conversion model
    // ------------------------------------------------------------------------

    // Bit offset of a channel (red, green, blue, alpha) within a format
    function automatic int unsigned chan_offset(input logic [2:0] fmt,
                                                input int unsigned ch);
        logic [19:0] pos;
        case (fmt)
            FMT_RGBA: pos = {5'd24, 5'd16, 5'd8,  5'd0};
            FMT_BGRA: pos = {5'd8,  5'd16, 5'd24, 5'd0};
            FMT_ARGB: pos = {5'd16, 5'd8,  5'd0,  5'd24};
            FMT_ABGR: pos = {5'd0,  5'd8,  5'd16, 5'd24};
            FMT_RGB:  pos = {5'd16, 5'd8,  5'd0,  5'd0};
            default:  pos = {5'd0,  5'd8,  5'd16, 5'd0};
        endcase
        return 32'(pos[(3 - ch) * 5 +: 5]);
    endfunction

    function automatic px_result_t predict_px(input logic [2:0]  sf,
                                              input logic [2:0]  df,
                                              input logic [1:0]  am,
                                              input logic [31:0] src,
                                              input logic [31:0] dst);
        px_result_t  res;
        logic [31:0] sp;
        logic [31:0] dp;
        logic [7:0]  chan [3];
        logic [7:0]  alpha;
        logic        four_byte;
        int unsigned sv;
        int unsigned dv;
        int unsigned av;
        res.pixel = '0;
        res.we    = 1'b0;
        // Unknown formats never write
        if (sf > FMT_BGR || df > FMT_BGR)
            return res;
        four_byte = (sf < FMT_RGB);
        sp = four_byte ? src : {8'h00, src[23:0]};
        dp = (df >= FMT_RGB) ? {8'h00, dst[23:0]} : dst;
        for (int c = 0; c < 3; c++)
            chan[c] = 8'(sp >> chan_offset(sf, c));
        // Three-byte sources carry no alpha and always write
        if (four_byte && am != MODE_STRAIGHT) begin
            alpha = 8'(sp >> chan_offset(sf, CH_A));
            if (alpha == 8'h00) begin
                if (sp != 32'h0 && am[1])
                    alpha = 8'hff;
                else
                    return res;
            end
            if (alpha != 8'hff) begin
                for (int c = 0; c < 3; c++) begin
                    sv = 32'(chan[c]);
                    dv = 32'(8'(dp >> chan_offset(df, c)));
                    av = 32'(alpha);
                    chan[c] = 8'((sv * av + dv * (255 - av)) / 255);
                end
            end
        end
        for (int c = 0; c < 3; c++)
            res.pixel |= 32'(chan[c]) << chan_offset(df, c);
        res.we = 1'b1;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus store and generators
    // ------------------------------------------------------------------------
    stim_t      stim_q[$];
    logic [2:0] gen_src_fmt = FMT_RGBA;
    int         n_px_queued = 0;
    int         n_cfg_queued = 0;

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
        stim_t s;
        s.is_cfg = 1'b1;
        s.idx    = idx;
        s.data   = data;
        s.src    = '0;
        s.dst    = '0;
        stim_q.push_back(s);
        n_cfg_queued++;
        if (idx == CFG_SRC_FORMAT)
            gen_src_fmt = data;
    endtask

    task automatic add_px(input logic [31:0] src, input logic [31:0] dst);
        stim_t s;
        s.is_cfg = 1'b0;
        s.idx    = '0;
        s.data   = '0;
        s.src    = src;
        s.dst    = dst;
        stim_q.push_back(s);
        n_px_queued++;
    endtask

    // Random pixel with its alpha byte steered toward the interesting values
    task automatic add_rand_px();
        logic [31:0] s;
        logic [7:0]  a;
        int unsigned off;
        int          pick;
        s    = $urandom;
        pick = $urandom_range(0, 19);
        off  = chan_offset(gen_src_fmt, CH_A);
        if (gen_src_fmt < FMT_RGB && pick < 18) begin
            if (pick < 5)
                a = 8'h00;
            else if (pick < 10)
                a = 8'hff;
            else if (pick == 10)
                a = 8'h01;
            else if (pick == 11)
                a = 8'hfe;
            else
                a = 8'($urandom);
            s = (s & ~(32'hff << off)) | (32'(a) << off);
            if (pick == 4)
                s = 32'h0;
        end
        add_px(s, $urandom);
    endtask

    function automatic logic [2:0] rand_fmt();
        if ($urandom_range(0, 15) == 0)
            return 3'($urandom_range(FMT_UNDEF_A, FMT_UNDEF_B));
        return 3'($urandom_range(FMT_RGBA, FMT_BGR));
    endfunction

    // ------------------------------------------------------------------------
    // Driver: register writes only with nothing in flight, pixels in bursts
    // ------------------------------------------------------------------------
    px_result_t predicted_px [int];
    logic [2:0] mdl_src_fmt;
    logic [2:0] mdl_dst_fmt;
    logic [1:0] mdl_mode;
    int         n_sent = 0;
    int         n_recv = 0;
    int         n_cfg_done = 0;
    int         burst_left;
    int         gap_left;
    stim_t      drv_item;
    logic       nxt_valid;
    logic       nxt_we;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_cfg_we    <= 1'b0;
            mdl_src_fmt = FMT_RGBA;
            mdl_dst_fmt = FMT_RGBA;
            mdl_mode    = MODE_STRAIGHT;
            burst_left  = 0;
            gap_left    = 0;
        end else begin
            nxt_we = 1'b0;

            // Track the write the block takes at this edge
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SRC_FORMAT: mdl_src_fmt = i_cfg_data;
                    CFG_DST_FORMAT: mdl_dst_fmt = i_cfg_data;
                    CFG_ALPHA_MODE: mdl_mode    = i_cfg_data[1:0];
                    default: ;
                endcase
                n_cfg_done <= n_cfg_done + 1;
            end

            // Predict the beat accepted at this edge
            if (i_in_valid && !o_in_stall) begin
                predicted_px[n_sent] = predict_px(mdl_src_fmt, mdl_dst_fmt, mdl_mode,
                                                  i_src_pixel, i_dst_pixel);
                n_sent <= n_sent + 1;
            end

            // Hold a stalled beat, otherwise pick the next action
            if (!(i_in_valid && o_in_stall)) begin
                nxt_valid = 1'b0;
                if (stim_q.size() > 0 && stim_q[0].is_cfg) begin
                    if (!i_in_valid && n_sent == n_recv) begin
                        drv_item = stim_q.pop_front();
                        nxt_we = 1'b1;
                        i_cfg_idx  <= drv_item.idx;
                        i_cfg_data <= drv_item.data;
                    end
                end else if (gap_left > 0) begin
                    gap_left--;
                end else if (stim_q.size() > 0) begin
                    drv_item = stim_q.pop_front();
                    nxt_valid = 1'b1;
                    i_src_pixel <= drv_item.src;
                    i_dst_pixel <= drv_item.dst;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                i_in_valid <= nxt_valid;
            end
            i_cfg_we <= nxt_we;
        end
    end

    // ------------------------------------------------------------------------
    // Result side stall pattern
    // ------------------------------------------------------------------------
    stall_style_t stall_style;
    int           style_left;
    int           stall_phase;
    int           stall_period;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_style = STALL_NONE;
            style_left  = 0;
            stall_phase = 0;
        end else begin
            // Switch to a new pattern now and then
            if (style_left == 0) begin
                stall_style  = stall_style_t'($urandom_range(0, 3));
                style_left   = $urandom_range(20, 150);
                stall_period = $urandom_range(2, 9);
                stall_phase  = 0;
            end else begin
                style_left--;
            end
            stall_phase++;
            case (stall_style)
                STALL_NONE:     i_out_stall <= 1'b0;
                STALL_RANDOM:   i_out_stall <= ($urandom_range(0, 2) == 0);
                STALL_PERIODIC: i_out_stall <= ((stall_phase % stall_period) == 0);
                default:        i_out_stall <= ((stall_phase % stall_period) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each result beat with the oldest prediction
    // ------------------------------------------------------------------------
    int         n_err = 0;
    int         n_written = 0;
    px_result_t want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (n_recv >= n_sent) begin
                $error("result beat with no pixel outstanding: out_pixel %h", o_out_pixel);
                n_err++;
            end else begin
                want = predicted_px[n_recv];
                predicted_px.delete(n_recv);
                if (o_write_enable !== want.we) begin
                    $error("beat %0d write_enable: expected %0b, got %0b",
                           n_recv, want.we, o_write_enable);
                    n_err++;
                end
                if (o_out_pixel !== want.pixel) begin
                    $error("beat %0d out_pixel: expected %h, got %h",
                           n_recv, want.pixel, o_out_pixel);
                    n_err++;
                end
                if (want.we)
                    n_written++;
                n_recv <= n_recv + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no beat moves for too long
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("no beat moved for %0d cycles, %0d results outstanding",
                   idle_cycles, n_sent - n_recv);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    int          phase_len;
    logic [2:0]  ph_src;
    logic [2:0]  ph_dst;
    logic [2:0]  ph_mode;

    initial begin
        // Defaults after reset: RGBA to RGBA, straight
        add_px(32'h0000_0000, 32'h0000_0000);
        add_px(32'hffff_ffff, 32'hffff_ffff);
        add_px(32'h1234_5678, 32'h9abc_def0);

        // Blend with zero alpha skipped, into a three-byte destination
        add_cfg(CFG_SRC_FORMAT, FMT_RGBA);
        add_cfg(CFG_DST_FORMAT, FMT_BGR);
        add_cfg(CFG_ALPHA_MODE, 3'(MODE_BLEND_CLEAR));
        add_px(32'h1122_3300, 32'h5566_7788);
        add_px(32'haabb_ccff, 32'h0000_0000);
        add_px(32'h40c0_ff80, 32'heeff_8000);
        add_px(32'hffff_ff01, 32'h0000_0000);
        add_px(32'h0000_00fe, 32'hffff_ffff);

        // Zero alpha taken as opaque unless the whole pixel is zero
        add_cfg(CFG_SRC_FORMAT, FMT_ARGB);
        add_cfg(CFG_DST_FORMAT, FMT_ABGR);
        add_cfg(CFG_ALPHA_MODE, 3'(MODE_BLEND_OPAQUE));
        add_px(32'h0000_0000, 32'h1234_5678);
        add_px(32'h0012_3456, 32'hffff_ffff);
        add_px(32'h7f80_8080, 32'h00c0_4020);
        add_px(32'hff01_0203, 32'h0000_0000);

        // Unused alpha mode behaves as the opaque one
        add_cfg(CFG_SRC_FORMAT, FMT_BGRA);
        add_cfg(CFG_DST_FORMAT, FMT_RGB);
        add_cfg(CFG_ALPHA_MODE, 3'(MODE_BLEND_ALT));
        add_px(32'h1020_3000, 32'h0000_0000);
        add_px(32'h0000_0000, 32'hffff_ffff);
        add_px(32'h3344_5580, 32'haa99_8877);

        // Three-byte sources ignore the top byte and always write
        add_cfg(CFG_SRC_FORMAT, FMT_RGB);
        add_cfg(CFG_DST_FORMAT, FMT_ARGB);
        add_cfg(CFG_ALPHA_MODE, {1'b1, MODE_BLEND_CLEAR});
        add_px(32'hff00_0000, 32'hffff_ffff);
        add_px(32'h00ab_cdef, 32'h0000_0000);
        add_px(32'hffff_ffff, 32'h0000_0000);
        add_cfg(CFG_SRC_FORMAT, FMT_BGR);
        add_cfg(CFG_DST_FORMAT, FMT_RGBA);
        add_px(32'h1234_5600, 32'h0000_0000);

        // Unknown formats produce no write; the spare index changes nothing
        add_cfg(CFG_SRC_FORMAT, FMT_UNDEF_A);
        add_cfg(CFG_ALPHA_MODE, 3'(MODE_STRAIGHT));
        add_px(32'hffff_ffff, 32'hffff_ffff);
        add_cfg(CFG_SRC_FORMAT, FMT_RGBA);
        add_cfg(CFG_DST_FORMAT, FMT_UNDEF_B);
        add_px(32'h1234_5678, 32'h0000_0000);
        add_cfg(CFG_DST_FORMAT, FMT_ABGR);
        add_cfg(CFG_UNUSED, 3'd7);
        add_px(32'h8899_aabb, 32'h0000_0000);

        // Random phases, each under a fresh register setting
        while (n_px_queued < RANDOM_PIXELS) begin
            ph_src  = rand_fmt();
            ph_dst  = rand_fmt();
            ph_mode = 3'($urandom_range(0, 7));
            case ($urandom_range(0, 5))
                0: add_cfg(CFG_ALPHA_MODE, ph_mode);
                1: begin
                    add_cfg(CFG_SRC_FORMAT, ph_src);
                    add_cfg(CFG_UNUSED, 3'($urandom));
                end
                default: begin
                    add_cfg(CFG_SRC_FORMAT, ph_src);
                    add_cfg(CFG_DST_FORMAT, ph_dst);
                    add_cfg(CFG_ALPHA_MODE, ph_mode);
                end
            endcase
            phase_len = $urandom_range(10, 120);
            repeat (phase_len)
                add_rand_px();
        end

        // Release reset
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for all beats to drain; look at the falling edge, once the
        // driver and monitor have settled, then allow for the pipeline depth
        while (stim_q.size() > 0 || i_in_valid || n_sent != n_recv)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d pixel beats across %0d register writes", n_sent, n_cfg_done);
        $display("%0d results written, %0d skipped", n_written, n_recv - n_written);
        if (n_err == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
